@@ hw/rtl/mf5_pkg.sv @@
// Shared types, constants and register codes of the 5x5 median filter.
package mf5_pkg;

  localparam int PIX_W           = 8;
  localparam int COL_W           = 11;
  localparam int ROW_W           = 13;
  localparam int DIST_W          = 3;
  localparam int WINDOW_SIZE_DEF = 5;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT      = 4096;
  localparam int JOB_DEPTH       = 4;
  localparam int RES_DEPTH       = 8;
  localparam int RES_CNT_W       = $clog2(RES_DEPTH + 1);
  localparam int ADDR_W          = 3;
  localparam int DATA_W          = 32;

  localparam logic [COL_W-1:0] WIDTH_RESET  = COL_W'(640);
  localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(480);

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } mf5_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             padding_beat;
  } mf5_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] median_value;
    logic             run_last;
    logic             frame_last;
  } mf5_result_t;

  // Classified work for one accepted pixel.
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [COL_W-1:0]  width;
    logic [DIST_W-1:0] d_hi;
    logic [DIST_W-1:0] d_lo;
    logic              last_row;
    logic              any;
  } mf5_job_ctrl_t;

endpackage

@@ hw/rtl/median_filter_5x5_core.sv @@
// Top level of the streaming 5x5 median filter with its configuration registers.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   input    | push / full          | item   : pixel, padding_beat
//   result   | pop / empty          | result : median_value, run_last, frame_last
//   config   | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
//
// Sustains one pixel per clock while the job queue has room. Only pixels that release a
// median leave a job, and the back end issues one result at a time, so a row end with
// three results keeps the back end busy while the next row's first pixels leave none;
// the job queue absorbs this. From accept to result the path runs through the line memory
// read, window, job queue, mask register and rank register. Reset is synchronous and clears
// counters, the window and all queues; the line memory is not cleared. Either side
// may stall freely: full rises only when the job queue backs up.
module median_filter_5x5_core #(
  parameter int WINDOW_SIZE = mf5_pkg::WINDOW_SIZE_DEF,
  parameter int MAX_WIDTH   = mf5_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  mf5_pkg::mf5_item_t           item,
  output logic                         empty,
  input  logic                         pop,
  output mf5_pkg::mf5_result_t         result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mf5_pkg::ADDR_W-1:0]   paddr,
  input  logic [mf5_pkg::DATA_W-1:0]   pwdata,
  output logic [mf5_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import mf5_pkg::*;

  localparam int WW = WINDOW_SIZE * WINDOW_SIZE * PIX_W;
  localparam int CW = $bits(mf5_job_ctrl_t);
  localparam int JW = CW + WW;

  logic [COL_W-1:0] image_width;
  logic [ROW_W-1:0] image_height;
  mf5_reg_t         reg_sel;

  logic          job_push;
  logic          job_pop;
  logic          job_full;
  logic          job_empty;
  mf5_job_ctrl_t job_ctrl_in;
  logic [WW-1:0] job_win_in;
  logic [JW-1:0] job_head;
  mf5_job_ctrl_t job_ctrl_out;
  logic [WW-1:0] job_win_out;
  logic [$clog2(JOB_DEPTH+1)-1:0] job_count;

  logic                 res_push;
  mf5_result_t          res_data;
  logic                 res_full;
  logic [RES_CNT_W-1:0] res_count;
  logic [$bits(mf5_result_t)-1:0] res_head;

  // Register file: address bit 2 picks the register.
  assign pready  = 1'b1;
  assign reg_sel = mf5_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[COL_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_IMAGE_WIDTH:  prdata = DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

  // Front end: counters, line memory and window; hands one job per releasing pixel.
  mf5_front #(
    .WIN_SIZE (WINDOW_SIZE),
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .item        (item),
    .image_width (image_width),
    .image_height(image_height),
    .job_push    (job_push),
    .job_ctrl    (job_ctrl_in),
    .job_win     (job_win_in),
    .job_full    (job_full)
  );

  // Job queue decouples the pixel rate from the bursty result expansion.
  mf5_fifo #(
    .WIDTH(JW),
    .DEPTH(JOB_DEPTH)
  ) u_job_q (
    .clk  (clk),
    .rst  (rst),
    .push (job_push),
    .pop  (job_pop),
    .wdata({job_ctrl_in, job_win_in}),
    .rdata(job_head),
    .full (job_full),
    .empty(job_empty),
    .count(job_count)
  );

  assign job_ctrl_out = mf5_job_ctrl_t'(job_head[JW-1 -: CW]);
  assign job_win_out  = job_head[WW-1:0];

  // Back end: one median per cycle, gated by free slots in the result queue.
  mf5_back #(
    .WIN_SIZE(WINDOW_SIZE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_empty(job_empty),
    .job_ctrl (job_ctrl_out),
    .job_win  (job_win_out),
    .job_pop  (job_pop),
    .res_count(res_count),
    .res_push (res_push),
    .res_data (res_data)
  );

  // Result queue; the head is presented while empty is low.
  mf5_fifo #(
    .WIDTH($bits(mf5_result_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .pop  (pop && !empty),
    .wdata(res_data),
    .rdata(res_head),
    .full (res_full),
    .empty(empty),
    .count(res_count)
  );

  assign result = mf5_result_t'(res_head);
endmodule

@@ hw/rtl/mf5_fifo.sv @@
// Small show-ahead synchronous queue built from registers.
module mf5_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic                       pop,
  input  logic [WIDTH-1:0]           wdata,
  output logic [WIDTH-1:0]           rdata,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

@@ hw/rtl/mf5_front.sv @@
// Front end: position counters, line memory, window update and job classification.
module mf5_front #(
  parameter int WIN_SIZE  = mf5_pkg::WINDOW_SIZE_DEF,
  parameter int MAX_WIDTH = mf5_pkg::MAX_WIDTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          push,
  output logic                                          full,
  input  mf5_pkg::mf5_item_t                            item,
  input  logic [mf5_pkg::COL_W-1:0]                     image_width,
  input  logic [mf5_pkg::ROW_W-1:0]                     image_height,
  output logic                                          job_push,
  output mf5_pkg::mf5_job_ctrl_t                        job_ctrl,
  output logic [WIN_SIZE*WIN_SIZE*mf5_pkg::PIX_W-1:0]   job_win,
  input  logic                                          job_full
);
  import mf5_pkg::*;

  localparam int PAD = WIN_SIZE / 2;
  localparam int NL  = WIN_SIZE - 1;
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int LW  = NL * PIX_W;
  localparam int WW  = WIN_SIZE * WIN_SIZE * PIX_W;
  localparam int XW  = ROW_W + 1;

  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;

  logic [COL_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [COL_W-1:0] c_cl;
  logic             last_col;
  logic             last_row;
  logic [WIN_SIZE-1:0] rowok;
  logic [PIX_W-1:0] pix;
  logic [AW-1:0]    addr0;
  mf5_job_ctrl_t    ctrl0;
  logic             acc;

  logic                s1_valid;
  logic [AW-1:0]       s1_addr;
  logic [PIX_W-1:0]    s1_pix;
  logic [WIN_SIZE-1:0] s1_rowok;
  mf5_job_ctrl_t       s1_ctrl;
  logic                s1_byp;
  logic [LW-1:0]       byp_data;
  logic                s1_fire;

  logic [LW-1:0] mem [MAX_WIDTH];
  logic [LW-1:0] rd_data;
  logic [LW-1:0] old_word;
  logic [LW-1:0] word_new;
  logic [WW-1:0] win;
  logic [WW-1:0] win_next;

  // A pixel that releases no median skips the job queue, so only real jobs wait on it.
  assign s1_fire = s1_valid && (!job_full || !s1_ctrl.any);
  assign full    = s1_valid && !s1_fire;
  assign acc     = push && !full;

  // Classify the incoming pixel.
  always_comb begin
    logic [XW-1:0] lo_w;
    logic [XW-1:0] hi_w;
    logic [XW-1:0] lo_base;
    if (image_width == '0) begin
      w_eff = COL_W'(1);
    end else if ({2'b00, image_width} > ROW_W'(MAX_WIDTH)) begin
      w_eff = COL_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = ROW_W'(1);
    end else if (image_height > ROW_W'(MAX_HEIGHT)) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
    if ({2'b00, column_count} > ROW_W'(MAX_WIDTH - 1)) begin
      c_cl = COL_W'(MAX_WIDTH - 1);
    end else begin
      c_cl = column_count;
    end
    last_col = (c_cl >= w_eff - 1'b1);
    last_row = ({1'b0, row_count} >= XW'(h_eff) + XW'(PAD) - XW'(1));
    for (int k = 0; k < WIN_SIZE; k++) begin
      rowok[k] = (XW'(row_count) + XW'(k) >= XW'(NL)) &&
                 (XW'(row_count) + XW'(k) <  XW'(h_eff) + XW'(NL));
    end
    pix   = item.padding_beat ? '0 : item.pixel;
    addr0 = AW'(c_cl);
    hi_w  = (XW'(c_cl) < XW'(PAD)) ? XW'(c_cl) : XW'(PAD);
    lo_base = last_col ? '0 : XW'(PAD);
    if (XW'(c_cl) + XW'(1) > XW'(w_eff)) begin
      lo_w = XW'(c_cl) + XW'(1) - XW'(w_eff);
      if (lo_w < lo_base) begin
        lo_w = lo_base;
      end
    end else begin
      lo_w = lo_base;
    end
    ctrl0.col      = c_cl;
    ctrl0.width    = w_eff;
    ctrl0.d_hi     = DIST_W'(hi_w);
    ctrl0.d_lo     = DIST_W'(lo_w);
    ctrl0.last_row = last_row;
    ctrl0.any      = ({1'b0, row_count} >= XW'(PAD)) && (lo_w <= hi_w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (acc) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + 1'b1;
      end else begin
        column_count <= c_cl + 1'b1;
      end
    end
  end

  // Line memory: one word per column holds the previous rows.
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_data <= mem[addr0];
    end
    if (s1_fire) begin
      mem[s1_addr] <= word_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_addr  <= addr0;
      s1_pix   <= pix;
      s1_rowok <= rowok;
      s1_ctrl  <= ctrl0;
      s1_byp   <= s1_fire && (addr0 == s1_addr);
      byp_data <= word_new;
    end
  end

  always_comb begin
    old_word = s1_byp ? byp_data : rd_data;
    for (int k = 0; k < NL - 1; k++) begin
      word_new[k*PIX_W +: PIX_W] = old_word[(k+1)*PIX_W +: PIX_W];
    end
    word_new[(NL-1)*PIX_W +: PIX_W] = s1_pix;
    for (int i = 0; i < WIN_SIZE; i++) begin
      for (int j = 0; j < WIN_SIZE - 1; j++) begin
        win_next[(i*WIN_SIZE+j)*PIX_W +: PIX_W] = win[(i*WIN_SIZE+j+1)*PIX_W +: PIX_W];
      end
      if (i < NL) begin
        win_next[(i*WIN_SIZE+WIN_SIZE-1)*PIX_W +: PIX_W] =
          s1_rowok[i] ? old_word[i*PIX_W +: PIX_W] : '0;
      end else begin
        win_next[(i*WIN_SIZE+WIN_SIZE-1)*PIX_W +: PIX_W] = s1_rowok[i] ? s1_pix : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_fire) begin
      win <= win_next;
    end
  end

  assign job_push = s1_fire && s1_ctrl.any;
  assign job_ctrl = s1_ctrl;
  assign job_win  = win_next;
endmodule

@@ hw/rtl/mf5_median.sv @@
// Rank network that picks the middle value of the window: registered compares, then a rank select.
module mf5_median #(
  parameter int WIN_SIZE = mf5_pkg::WINDOW_SIZE_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  input  logic [WIN_SIZE*WIN_SIZE*mf5_pkg::PIX_W-1:0] in_vals,
  input  logic                                        in_run_last,
  input  logic                                        in_frame_last,
  output logic                                        out_valid,
  output mf5_pkg::mf5_result_t                        out_res
);
  import mf5_pkg::*;

  localparam int N   = WIN_SIZE * WIN_SIZE;
  localparam int MID = N / 2;

  logic [N-1:0]         lt [N];
  logic [N*PIX_W-1:0]   vals;
  logic                 run_last;
  logic                 frame_last;

  // Rank bit: value j sorts before value i, ties broken by position.
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        lt[i][j] <= (in_vals[j*PIX_W +: PIX_W] < in_vals[i*PIX_W +: PIX_W]) ||
                    ((in_vals[j*PIX_W +: PIX_W] == in_vals[i*PIX_W +: PIX_W]) && (j < i));
      end
    end
    vals       <= in_vals;
    run_last   <= in_run_last;
    frame_last <= in_frame_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_comb begin
    logic [PIX_W-1:0] med;
    med = '0;
    for (int i = 0; i < N; i++) begin
      if ($countones(lt[i]) == MID) begin
        med = med | vals[i*PIX_W +: PIX_W];
      end
    end
    out_res.median_value = med;
    out_res.run_last     = run_last;
    out_res.frame_last   = frame_last;
  end
endmodule

@@ hw/rtl/mf5_back.sv @@
// Back end: expands each job into its output positions and feeds the median network.
module mf5_back #(
  parameter int WIN_SIZE = mf5_pkg::WINDOW_SIZE_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        job_empty,
  input  mf5_pkg::mf5_job_ctrl_t                      job_ctrl,
  input  logic [WIN_SIZE*WIN_SIZE*mf5_pkg::PIX_W-1:0] job_win,
  output logic                                        job_pop,
  input  logic [mf5_pkg::RES_CNT_W-1:0]               res_count,
  output logic                                        res_push,
  output mf5_pkg::mf5_result_t                        res_data
);
  import mf5_pkg::*;

  localparam int PAD = WIN_SIZE / 2;
  localparam int N   = WIN_SIZE * WIN_SIZE;
  localparam int XW  = COL_W + 2;

  logic              first;
  logic [DIST_W-1:0] d_cur;
  logic [DIST_W-1:0] d;
  logic              credit;
  logic              go;
  logic              issue;
  logic              at_lo;

  logic [N*PIX_W-1:0] masked;
  logic               frame_hit;

  logic               v0;
  logic [N*PIX_W-1:0] vals0;
  logic               run_last0;
  logic               frame_last0;

  assign d      = first ? job_ctrl.d_hi : d_cur;
  assign at_lo  = (d == job_ctrl.d_lo);
  // Count results already headed for the output queue.
  assign credit = (XW'(res_count) + XW'(v0) + XW'(res_push)) < XW'(RES_DEPTH);
  assign go     = !job_empty && (!job_ctrl.any || credit);
  assign issue  = go && job_ctrl.any;
  assign job_pop = go && (!job_ctrl.any || at_lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b1;
      d_cur <= '0;
    end else if (issue) begin
      if (at_lo) begin
        first <= 1'b1;
      end else begin
        first <= 1'b0;
        d_cur <= d - 1'b1;
      end
    end
  end

  // Zero taps outside the image or beyond the loaded columns.
  always_comb begin
    logic ok;
    int   j;
    for (int t = 0; t < WIN_SIZE; t++) begin
      ok = (XW'(job_ctrl.col) + XW'(t) >= XW'(d) + XW'(PAD)) &&
           (XW'(job_ctrl.col) + XW'(t) + XW'(1) <= XW'(job_ctrl.width) + XW'(d) + XW'(PAD)) &&
           (XW'(t) + XW'(PAD) <= XW'(WIN_SIZE - 1) + XW'(d));
      j = t + PAD - int'(d);
      for (int i = 0; i < WIN_SIZE; i++) begin
        if (ok) begin
          masked[(i*WIN_SIZE+t)*PIX_W +: PIX_W] = job_win[(i*WIN_SIZE+j)*PIX_W +: PIX_W];
        end else begin
          masked[(i*WIN_SIZE+t)*PIX_W +: PIX_W] = '0;
        end
      end
    end
    frame_hit = job_ctrl.last_row &&
                ((job_ctrl.col - COL_W'(d)) == (job_ctrl.width - 1'b1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      vals0       <= masked;
      run_last0   <= at_lo;
      frame_last0 <= frame_hit;
    end
  end

  mf5_median #(
    .WIN_SIZE(WIN_SIZE)
  ) u_median (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (v0),
    .in_vals      (vals0),
    .in_run_last  (run_last0),
    .in_frame_last(frame_last0),
    .out_valid    (res_push),
    .out_res      (res_data)
  );
endmodule
